// ===== rtl/ktia_pkg.sv =====
package ktia_pkg;

   localparam int CAPACITY_DEFAULT = 1024;
   localparam int DATA_W = 64;
   localparam int COUNT_W = 11;
   localparam int CMD_W = 2;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NEW = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] load_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

endpackage

// ===== rtl/key_to_id_assign_table_unit.sv =====
// lookup and load: a linear scan of the key memory, one entry per cycle through its
// registered read port, ends on a hit or once every occupied entry is compared; the
// result strobe is registered and follows in the cycle after the scan ends
// clear and unused commands give their result strobe in the cycle after the transfer
// busy is high during the scan, so items are taken one at a time; results cannot be stalled
// reset empties the table at once (entry count to zero, no clearing pass)
module key_to_id_assign_table_unit
   import ktia_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff, state_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic pend_ff, pend_in;
   logic [AW-1:0] pend_idx_ff, pend_idx_in;
   req_type req_ff, req_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [DATA_W-1:0] rsp_value;
   logic [STATUS_W-1:0] rsp_status;
   logic [CW+COUNT_W-1:0] cnt_wide;
   logic [CW-1:0] occ_plus;
   logic [CW+DATA_W-1:0] nv_wide;

   logic key_wr_en, val_wr_en;
   logic [AW-1:0] wr_addr;
   logic [DATA_W-1:0] key_wr_data, val_wr_data;
   logic [DATA_W-1:0] key_rd, val_rd;
   logic hit, miss, accept, is_lookup;

   ktia_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_wr_data),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (key_rd)
   );

   ktia_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (wr_addr),
      .wr_data (val_wr_data),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (val_rd)
   );

   assign busy = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign is_lookup = (req_ff.command == CMD_LOOKUP);
   assign occ_plus = occ_ff + CW'(1);
   assign nv_wide = {{DATA_W{1'b0}}, occ_plus};
   assign hit = pend_ff && (key_rd == $unsigned(req_ff.key));
   assign miss = !pend_ff && (idx_ff >= occ_ff);
   assign key_wr_data = $unsigned(req_ff.key);

   always_comb begin
      state_in = state_ff;
      occ_in = occ_ff;
      idx_in = idx_ff;
      pend_in = pend_ff;
      pend_idx_in = pend_idx_ff;
      req_in = req_ff;
      rsp_valid_in = 1'b0;
      rsp_value = '0;
      rsp_status = STAT_DONE;
      key_wr_en = 1'b0;
      val_wr_en = 1'b0;
      wr_addr = occ_ff[AW-1:0];
      val_wr_data = nv_wide[DATA_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               case (req_data.command)
                  CMD_LOOKUP, CMD_LOAD: begin
                     state_in = ST_SCAN;
                     idx_in = '0;
                     pend_in = 1'b0;
                  end
                  CMD_CLEAR: begin
                     occ_in = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (is_lookup) begin
                  rsp_value = val_rd;
               end else begin
                  val_wr_en = 1'b1;
                  wr_addr = pend_idx_ff;
                  val_wr_data = $unsigned(req_ff.load_value);
               end
            end else if (miss) begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (occ_ff >= CW'(CAPACITY)) begin
                  rsp_status = STAT_FULL;
               end else begin
                  key_wr_en = 1'b1;
                  val_wr_en = 1'b1;
                  occ_in = occ_plus;
                  rsp_status = STAT_NEW;
                  if (is_lookup) begin
                     rsp_value = nv_wide[DATA_W-1:0];
                  end else begin
                     val_wr_data = $unsigned(req_ff.load_value);
                  end
               end
            end else begin
               pend_in = (idx_ff < occ_ff);
               pend_idx_in = idx_ff[AW-1:0];
               if (idx_ff < occ_ff) begin
                  idx_in = idx_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign cnt_wide = {{COUNT_W{1'b0}}, occ_in};

   always_comb begin
      rsp_in = rsp_ff;
      if (rsp_valid_in) begin
         rsp_in.result_value = $signed(rsp_value);
         rsp_in.status = rsp_status;
         rsp_in.entry_count = cnt_wide[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff <= '0;
         idx_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff <= occ_in;
         idx_ff <= idx_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_idx_ff <= pend_idx_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= occ_ff))
      else $error("scan index past entry count");

   a_new_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STAT_NEW) |-> (occ_ff == $past(occ_ff) + CW'(1)))
      else $error("insert did not grow entry count by one");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.command == CMD_CLEAR) |=> (rsp_valid_ff && occ_ff == '0))
      else $error("clear did not empty table");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !$past(busy && state_in == ST_SCAN))
      else $error("result while scan continues");

endmodule

// ===== rtl/ktia_ram.sv =====
module ktia_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
